/* hdl/rtcl_pkg.sv */
`timescale 1ns / 1ps
// rtcl_pkg: shared types, register indexes and the month-length table
// for the clock reading to local time block; no dependencies

package rtcl_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BCD_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWELVE_HR  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TZ_OFFSET  = 2'd2;

   localparam logic signed [CSR_DATA_W-1:0] TZ_MIN = -5'sd12;
   localparam logic signed [CSR_DATA_W-1:0] TZ_MAX = 5'sd12;

   typedef struct packed {
      logic [7:0] raw_second;
      logic [7:0] raw_minute;
      logic [7:0] raw_hour;
      logic [7:0] raw_day;
      logic [7:0] raw_month;
      logic [7:0] raw_year;
   } req_data_type;

   typedef struct packed {
      logic [5:0] local_second;
      logic [5:0] local_minute;
      logic [4:0] local_hour;
      logic [4:0] local_day;
      logic [3:0] local_month;
      logic [6:0] local_year;
   } rsp_data_type;

   typedef struct packed {
      logic                         bcd_mode;
      logic                         twelve_hour_mode;
      logic signed [CSR_DATA_W-1:0] tz_offset;
   } cfg_type;

   // days in month, february fixed at 28
   function automatic logic [4:0] month_len(input logic [3:0] mon);
      logic [4:0] len;
      case (mon)
         4'd2:                      len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // two-digit bcd to binary, nibbles above nine taken as they stand
   function automatic logic [7:0] bcd_dec(input logic [7:0] b);
      return 8'(b[3:0]) + (8'(b[7:4]) << 3) + (8'(b[7:4]) << 1);
   endfunction

endpackage

/* hdl/rtcl_if.sv */
`timescale 1ns / 1ps
// rtcl_req_if and rtcl_rsp_if: valid/ready channels for clock readings
// and local time results; depends on rtcl_pkg

interface rtcl_req_if;
   import rtcl_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rtcl_rsp_if;
   import rtcl_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/rtc_reading_to_local_time_core.sv */
`timescale 1ns / 1ps
// rtc_reading_to_local_time_core: raw clock register bytes to binary local time
// depends on rtcl_pkg, rtcl_if, rtcl_csr, rtcl_decode
//
//  channel   direction  handshake          contents
//  req_chan  in         valid/ready        six raw clock register bytes
//  rsp_chan  out        valid/ready        local second..year, binary
//  csr_*     in         write enable only  bcd mode, twelve hour mode, offset
//
// one reading accepted per cycle unless both stages hold data; rsp valid
// follows the req via the input register, decode logic and result register
// synchronous reset clears the stage valid bits, presets the config registers
// the two stages advance independently, so req_ready stays high while a
// result waits unless both stages hold data; rsp_ready feeds req_ready

module rtc_reading_to_local_time_core (
   input  logic                              clock,
   input  logic                              reset,
   rtcl_req_if.sink                          req_chan,
   rtcl_rsp_if.source                        rsp_chan,
   input  logic                              csr_wen,
   input  logic [rtcl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rtcl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtcl_pkg::*;

   cfg_type      cfg;
   logic         in_v_ff, in_v_in;
   req_data_type in_data_ff, in_data_in;
   logic         out_v_ff, out_v_in;
   rsp_data_type out_data_ff, out_data_in;
   rsp_data_type dec_data;
   logic         in_ready;
   logic         out_load;

   rtcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rtcl_decode u_decode (
      .cfg  (cfg),
      .din  (in_data_ff),
      .dout (dec_data)
   );

   // result register takes the decoded item when empty or being drained
   assign out_load = in_v_ff && (!out_v_ff || rsp_chan.ready);
   // input register frees up when its item moves on
   assign in_ready = !in_v_ff || out_load;

   always_comb begin
      in_v_in    = in_v_ff;
      in_data_in = in_data_ff;
      if (in_ready) begin
         in_v_in    = req_chan.valid;
         in_data_in = req_chan.data;
      end
      out_v_in    = out_v_ff;
      out_data_in = out_data_ff;
      if (out_load) begin
         out_v_in    = 1'b1;
         out_data_in = dec_data;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign req_chan.ready = in_ready;
   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // a new result only appears after the input stage held an item
   a_result_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(in_v_ff))
      else $error("result appeared with empty input stage");

   // back-pressure only when both stages are occupied
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (in_v_ff && out_v_ff && !rsp_chan.ready))
      else $error("input stalled with room in the pipeline");

   // offset register never leaves its legal range
   a_tz_in_range: assert property (@(posedge clock) disable iff (reset)
      (cfg.tz_offset >= TZ_MIN) && (cfg.tz_offset <= TZ_MAX))
      else $error("offset register out of range");

   // decoded time fields stay within calendar bounds
   a_result_bounds: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_data_ff.local_hour <= 5'd23 && out_data_ff.local_day != 5'd0
         && out_data_ff.local_month != 4'd0 && out_data_ff.local_month <= 4'd12
         && out_data_ff.local_year <= 7'd99))
      else $error("result field out of range");
`endif

endmodule

/* hdl/rtcl_csr.sv */
`timescale 1ns / 1ps
// rtcl_csr: configuration registers with range check on the offset
// depends on rtcl_pkg

module rtcl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [rtcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rtcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rtcl_pkg::cfg_type                   cfg
);
   import rtcl_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic signed [CSR_DATA_W-1:0] tz_wr;

   assign tz_wr = signed'(csr_wdata);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_BCD_MODE:  cfg_in.bcd_mode = csr_wdata[0];
            CSR_TWELVE_HR: cfg_in.twelve_hour_mode = csr_wdata[0];
            CSR_TZ_OFFSET: begin
               // out-of-range offsets leave the old value
               if (tz_wr >= TZ_MIN && tz_wr <= TZ_MAX) cfg_in.tz_offset = tz_wr;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bcd_mode         <= 1'b1;
         cfg_ff.twelve_hour_mode <= 1'b0;
         cfg_ff.tz_offset        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/rtcl_decode.sv */
`timescale 1ns / 1ps
// rtcl_decode: combinational decode, clamp, twelve hour conversion, offset and date rollover
// depends on rtcl_pkg

module rtcl_decode (
   input  rtcl_pkg::cfg_type       cfg,
   input  rtcl_pkg::req_data_type  din,
   output rtcl_pkg::rsp_data_type  dout
);
   import rtcl_pkg::*;

   logic [7:0]        sec_f, min_f, day_f, mon_f, year_f;
   logic [5:0]        sec_c, min_c;
   logic [4:0]        day_c;
   logic [3:0]        mon_c;
   logic [6:0]        year_c;
   logic [6:0]        hour_base;
   logic [7:0]        hour_12;
   logic [4:0]        hour_c;
   logic signed [6:0] hour_sum;
   logic [3:0]        mon_prev;

   always_comb begin
      sec_f  = cfg.bcd_mode ? bcd_dec(din.raw_second) : din.raw_second;
      min_f  = cfg.bcd_mode ? bcd_dec(din.raw_minute) : din.raw_minute;
      day_f  = cfg.bcd_mode ? bcd_dec(din.raw_day)    : din.raw_day;
      mon_f  = cfg.bcd_mode ? bcd_dec(din.raw_month)  : din.raw_month;
      year_f = cfg.bcd_mode ? bcd_dec(din.raw_year)   : din.raw_year;

      sec_c  = (sec_f > 8'd59) ? 6'd59 : sec_f[5:0];
      min_c  = (min_f > 8'd59) ? 6'd59 : min_f[5:0];
      year_c = (year_f > 8'd99) ? 7'd99 : year_f[6:0];
      day_c  = (day_f == 8'd0) ? 5'd1 : ((day_f > 8'd31) ? 5'd31 : day_f[4:0]);
      mon_c  = (mon_f == 8'd0) ? 4'd1 : ((mon_f > 8'd12) ? 4'd12 : mon_f[3:0]);

      // hour byte: bit 7 is the pm flag; in bcd mode only bits 6..4 form the tens digit
      if (cfg.bcd_mode)
         hour_base = 7'(din.raw_hour[3:0]) + (7'(din.raw_hour[6:4]) << 3)
                   + (7'(din.raw_hour[6:4]) << 1);
      else
         hour_base = din.raw_hour[6:0];

      hour_12 = {1'b0, hour_base};
      if (cfg.twelve_hour_mode) begin
         if (hour_base == 7'd12) hour_12 = 8'd0;
         if (din.raw_hour[7]) hour_12 = hour_12 + 8'd12;
      end
      hour_c = (hour_12 > 8'd23) ? 5'd23 : hour_12[4:0];

      hour_sum = signed'({2'b00, hour_c}) + signed'({{2{cfg.tz_offset[4]}}, cfg.tz_offset});

      mon_prev = (mon_c == 4'd1) ? 4'd12 : mon_c - 4'd1;

      dout.local_second = sec_c;
      dout.local_minute = min_c;
      dout.local_hour   = hour_sum[4:0];
      dout.local_day    = day_c;
      dout.local_month  = mon_c;
      dout.local_year   = year_c;

      if (hour_sum >= 7'sd24) begin
         dout.local_hour = 5'(hour_sum - 7'sd24);
         if (day_c >= month_len(mon_c)) begin
            dout.local_day = 5'd1;
            if (mon_c == 4'd12) begin
               dout.local_month = 4'd1;
               dout.local_year  = (year_c == 7'd99) ? 7'd0 : year_c + 7'd1;
            end else begin
               dout.local_month = mon_c + 4'd1;
            end
         end else begin
            dout.local_day = day_c + 5'd1;
         end
      end else if (hour_sum[6]) begin
         dout.local_hour = 5'(hour_sum + 7'sd24);
         if (day_c == 5'd1) begin
            dout.local_month = mon_prev;
            dout.local_day   = month_len(mon_prev);
            if (mon_c == 4'd1)
               dout.local_year = (year_c == 7'd0) ? 7'd99 : year_c - 7'd1;
         end else begin
            dout.local_day = day_c - 5'd1;
         end
      end
   end

endmodule
